[rtl/ocr_pkg.sv]
// ----------------------------------------------------------------------------
// ocr_pkg: shared types and constants of the orbit camera rotator
// Payload word types, opcodes, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none
package ocr_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int CordicStepsMax     = 30;

   localparam logic [1:0] OP_YAW   = 2'd0;
   localparam logic [1:0] OP_PITCH = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [2:0] REG_PIVOT_X = 3'd0;
   localparam logic [2:0] REG_PIVOT_Y = 3'd1;
   localparam logic [2:0] REG_PIVOT_Z = 3'd2;
   localparam logic [2:0] REG_UP_X    = 3'd3;
   localparam logic [2:0] REG_UP_Y    = 3'd4;
   localparam logic [2:0] REG_UP_Z    = 3'd5;

   localparam logic [63:0] ANG_COEF = 64'd447981339002;
   // The coefficient fits in 39 bits; it is applied as a low and a high part.
   localparam logic [19:0] ANG_COEF_LO = ANG_COEF[19:0];
   localparam logic [18:0] ANG_COEF_HI = ANG_COEF[38:20];
   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
   localparam logic signed [31:0] Q_ONE = 32'sd65536;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] amount;
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] upv_x;
      logic signed [31:0] upv_y;
      logic signed [31:0] upv_z;
      logic signed [31:0] rightv_x;
      logic signed [31:0] rightv_y;
      logic signed [31:0] rightv_z;
   } rsp_word_type;

   // Datapath operations, one per controller step.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_PHASE,     // latch low part of the phase product
      DP_PHASE_HI,  // add high part of the phase product
      DP_FOLD,      // quadrant fold, CORDIC init
      DP_CORDIC,    // one CORDIC iteration
      DP_FLIP,      // negate cos/sin if folded
      DP_SETVEC,    // select vector and base, compute D
      DP_MUL,       // one multiply into the accumulator
      DP_DOT,       // saturate dot
      DP_N0,        // store n0, n1
      DP_N2,        // store n2
      DP_RES,       // saturate and write back one component
      DP_LOAD       // load position
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] vec;   // 0 pos, 1 dir, 2 up, 3 right
      logic [1:0] comp;  // component index
      logic [3:0] term;  // multiply selector
      logic [4:0] iter;  // CORDIC iteration
   } dp_cmd_type;

   function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
      case (i)
         5'd0:  atan_entry = 32'sd536870912;
         5'd1:  atan_entry = 32'sd316933406;
         5'd2:  atan_entry = 32'sd167458907;
         5'd3:  atan_entry = 32'sd85004756;
         5'd4:  atan_entry = 32'sd42667331;
         5'd5:  atan_entry = 32'sd21354465;
         5'd6:  atan_entry = 32'sd10679838;
         5'd7:  atan_entry = 32'sd5340245;
         5'd8:  atan_entry = 32'sd2670163;
         5'd9:  atan_entry = 32'sd1335086;
         5'd10: atan_entry = 32'sd667544;
         5'd11: atan_entry = 32'sd333772;
         5'd12: atan_entry = 32'sd166886;
         5'd13: atan_entry = 32'sd83443;
         5'd14: atan_entry = 32'sd41722;
         5'd15: atan_entry = 32'sd20861;
         5'd16: atan_entry = 32'sd10430;
         5'd17: atan_entry = 32'sd5215;
         5'd18: atan_entry = 32'sd2608;
         5'd19: atan_entry = 32'sd1304;
         5'd20: atan_entry = 32'sd652;
         5'd21: atan_entry = 32'sd326;
         5'd22: atan_entry = 32'sd163;
         5'd23: atan_entry = 32'sd81;
         5'd24: atan_entry = 32'sd41;
         5'd25: atan_entry = 32'sd20;
         5'd26: atan_entry = 32'sd10;
         5'd27: atan_entry = 32'sd5;
         5'd28: atan_entry = 32'sd3;
         5'd29: atan_entry = 32'sd1;
         default: atan_entry = 32'sd0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

endpackage
`default_nettype wire

[rtl/ocr_datapath.sv]
// ----------------------------------------------------------------------------
// ocr_datapath: registers and arithmetic of the orbit camera rotator
// Holds the camera vectors, the CORDIC unit, a 32x21 phase multiplier used
// twice per yaw or pitch and one shared 32x34 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module ocr_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ocr_pkg::dp_cmd_type  cmd,
   input  wire ocr_pkg::req_word_type req_word,
   input  wire logic                 req_take,
   input  wire logic signed [31:0]   pivot [3],
   input  wire logic signed [31:0]   up_axis [3],
   output ocr_pkg::rsp_word_type     state_word
);
   import ocr_pkg::*;

   logic signed [31:0] vec_ff [4][3];
   logic signed [31:0] ax_ff [3];
   logic signed [31:0] base_ff [3];
   logic signed [31:0] d_ff [3];
   logic signed [31:0] n0_ff [3];
   logic signed [31:0] n1_ff [3];
   logic signed [31:0] n2_ff [3];
   logic signed [31:0] dot_ff;
   logic signed [65:0] acc_ff;
   logic signed [65:0] prod_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [32:0] cz_ff;
   logic               flip_ff;
   logic [1:0]         op_ff;
   logic signed [31:0] amount_ff;
   logic signed [31:0] newpos_ff [3];
   logic [63:0]        phase_ff;

   logic signed [31:0] ma;
   logic signed [33:0] mb;
   logic signed [65:0] mul_out;
   logic signed [31:0] ph;
   logic [4:0]         sh;
   logic [19:0]        phase_coef;
   logic signed [52:0] phase_prod;

   // Multiplier operand select, per term code.
   always_comb begin
      ma = 32'sd0;
      mb = 34'sd0;
      case (cmd.term)
         4'd0: begin ma = d_ff[0]; mb = 34'(ax_ff[0]); end
         4'd1: begin ma = d_ff[1]; mb = 34'(ax_ff[1]); end
         4'd2: begin ma = d_ff[2]; mb = 34'(ax_ff[2]); end
         4'd3: begin ma = dot_ff; mb = 34'(ax_ff[cmd.comp]); end
         4'd4: begin ma = n1_ff[1]; mb = 34'(ax_ff[2]); end
         4'd5: begin ma = n1_ff[2]; mb = 34'(ax_ff[1]); end
         4'd6: begin ma = n1_ff[2]; mb = 34'(ax_ff[0]); end
         4'd7: begin ma = n1_ff[0]; mb = 34'(ax_ff[2]); end
         4'd8: begin ma = n1_ff[0]; mb = 34'(ax_ff[1]); end
         4'd9: begin ma = n1_ff[1]; mb = 34'(ax_ff[0]); end
         4'd10: begin ma = n1_ff[cmd.comp]; mb = cx_ff; end
         4'd11: begin ma = n2_ff[cmd.comp]; mb = cy_ff; end
         default: begin ma = 32'sd0; mb = 34'sd0; end
      endcase
   end

   assign mul_out = 66'(ma) * 66'(mb);
   assign ph = phase_ff[63:32];
   assign sh = cmd.iter;

   // The phase product is built from the low 20 and the high 19 bits of the
   // coefficient, low part first; the sum is taken modulo 2^64.
   assign phase_coef = (cmd.op == DP_PHASE_HI) ? 20'(ANG_COEF_HI) : ANG_COEF_LO;
   assign phase_prod = amount_ff * $signed({1'b0, phase_coef});

   function automatic logic signed [65:0] rq(input logic signed [65:0] p);
      rq = (p + 66'sd32768) >>> 16;
   endfunction
   function automatic logic signed [65:0] rc(input logic signed [65:0] p);
      rc = (p + 66'sd536870912) >>> 30;
   endfunction

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff     <= req_word.opcode;
         amount_ff <= req_word.amount;
         newpos_ff[0] <= req_word.new_pos_x;
         newpos_ff[1] <= req_word.new_pos_y;
         newpos_ff[2] <= req_word.new_pos_z;
      end
      prod_ff <= mul_out;
      if (reset) begin
         for (int v = 0; v < 4; v++)
            for (int i = 0; i < 3; i++) vec_ff[v][i] <= 32'sd0;
         vec_ff[1][2] <= -Q_ONE;
         vec_ff[2][1] <= Q_ONE;
         vec_ff[3][0] <= Q_ONE;
      end else begin
         case (cmd.op)
            DP_PHASE: begin
               phase_ff <= 64'(phase_prod) + 64'd2147483648;
               if (op_ff == OP_YAW) ax_ff <= up_axis;
               else ax_ff <= vec_ff[3];
            end
            DP_PHASE_HI: begin
               phase_ff <= phase_ff + (64'(phase_prod) << 20);
            end
            DP_FOLD: begin
               cx_ff <= CORDIC_K;
               cy_ff <= 34'sd0;
               if (ph > 32'sd1073741824) begin
                  cz_ff <= 33'(ph) - 33'sd2147483648; flip_ff <= 1'b1;
               end else if (ph < -32'sd1073741824) begin
                  cz_ff <= 33'(ph) + 33'sd2147483648; flip_ff <= 1'b1;
               end else begin
                  cz_ff <= 33'(ph); flip_ff <= 1'b0;
               end
            end
            DP_CORDIC: begin
               if (!cz_ff[32]) begin
                  cx_ff <= cx_ff - (cy_ff >>> sh);
                  cy_ff <= cy_ff + (cx_ff >>> sh);
                  cz_ff <= cz_ff - 33'(atan_entry(sh));
               end else begin
                  cx_ff <= cx_ff + (cy_ff >>> sh);
                  cy_ff <= cy_ff - (cx_ff >>> sh);
                  cz_ff <= cz_ff + 33'(atan_entry(sh));
               end
            end
            DP_FLIP: begin
               if (flip_ff) begin cx_ff <= -cx_ff; cy_ff <= -cy_ff; end
            end
            DP_SETVEC: begin
               for (int i = 0; i < 3; i++) begin
                  base_ff[i] <= (cmd.vec == 2'd0) ? pivot[i] : 32'sd0;
                  d_ff[i] <= sat32(66'(vec_ff[cmd.vec][i]) -
                     ((cmd.vec == 2'd0) ? 66'(pivot[i]) : 66'sd0));
               end
               acc_ff <= 66'sd0;
            end
            DP_MUL: begin
               // prod_ff holds the product selected in the previous cycle.
               case (cmd.term)
                  4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8:
                     acc_ff <= acc_ff + rq(prod_ff);
                  4'd5, 4'd7, 4'd9: acc_ff <= acc_ff - rq(prod_ff);
                  default: acc_ff <= acc_ff + rc(prod_ff);
               endcase
            end
            DP_DOT: begin
               dot_ff <= sat32(acc_ff);
               acc_ff <= 66'sd0;
            end
            DP_N0: begin
               n0_ff[cmd.comp] <= sat32(acc_ff);
               n1_ff[cmd.comp] <= sat32(66'(d_ff[cmd.comp]) - 66'(sat32(acc_ff)));
               acc_ff <= 66'sd0;
            end
            DP_N2: begin
               n2_ff[cmd.comp] <= sat32(acc_ff);
               acc_ff <= 66'sd0;
            end
            DP_RES: begin
               vec_ff[cmd.vec][cmd.comp] <= sat32(acc_ff + 66'(base_ff[cmd.comp]) +
                                                  66'(n0_ff[cmd.comp]));
               acc_ff <= 66'sd0;
            end
            DP_LOAD: vec_ff[0] <= newpos_ff;
            default: ;
         endcase
      end
   end

   assign state_word = '{pos_x: vec_ff[0][0], pos_y: vec_ff[0][1], pos_z: vec_ff[0][2],
                         dir_x: vec_ff[1][0], dir_y: vec_ff[1][1], dir_z: vec_ff[1][2],
                         upv_x: vec_ff[2][0], upv_y: vec_ff[2][1], upv_z: vec_ff[2][2],
                         rightv_x: vec_ff[3][0], rightv_y: vec_ff[3][1],
                         rightv_z: vec_ff[3][2]};
endmodule
`default_nettype wire

[rtl/ocr_controller.sv]
// ----------------------------------------------------------------------------
// ocr_controller: sequencer of the orbit camera rotator
// Steps the datapath through phase, CORDIC and the Rodrigues terms, or a load.
// ----------------------------------------------------------------------------
`default_nettype none
module ocr_controller #(
   parameter int CORDIC_STEPS = ocr_pkg::CordicStepsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_opcode,
   output logic                   req_stall,
   output logic                   req_take,
   output ocr_pkg::dp_cmd_type    cmd,
   output logic                   done
);
   import ocr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_PHASE, S_PHASE_HI, S_FOLD, S_CORDIC, S_FLIP, S_SETVEC,
      S_SEL, S_ACC, S_DONE
   } state_type;

   localparam logic [4:0] LastIter = 5'(CORDIC_STEPS - 1);

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [1:0] vec_ff, vec_in;
   logic [4:0] iter_ff, iter_in;
   logic [4:0] step_ff, step_in;  // Rodrigues micro-step within one vector

   // Micro-step table: term code, component and finishing op.
   logic [3:0] st_term;
   logic [1:0] st_comp;
   dp_op_type  st_fin;
   logic       st_last_mul;
   always_comb begin
      st_term = 4'd0; st_comp = 2'd0; st_fin = DP_NOP; st_last_mul = 1'b0;
      case (step_ff)
         5'd0: begin st_term = 4'd0; end
         5'd1: begin st_term = 4'd1; end
         5'd2: begin st_term = 4'd2; st_fin = DP_DOT; st_last_mul = 1'b1; end
         5'd3: begin st_term = 4'd3; st_comp = 2'd0; st_fin = DP_N0; st_last_mul = 1'b1; end
         5'd4: begin st_term = 4'd3; st_comp = 2'd1; st_fin = DP_N0; st_last_mul = 1'b1; end
         5'd5: begin st_term = 4'd3; st_comp = 2'd2; st_fin = DP_N0; st_last_mul = 1'b1; end
         5'd6: begin st_term = 4'd4; end
         5'd7: begin st_term = 4'd5; st_comp = 2'd0; st_fin = DP_N2; st_last_mul = 1'b1; end
         5'd8: begin st_term = 4'd6; end
         5'd9: begin st_term = 4'd7; st_comp = 2'd1; st_fin = DP_N2; st_last_mul = 1'b1; end
         5'd10: begin st_term = 4'd8; end
         5'd11: begin st_term = 4'd9; st_comp = 2'd2; st_fin = DP_N2; st_last_mul = 1'b1; end
         5'd12: begin st_term = 4'd10; st_comp = 2'd0; end
         5'd13: begin st_term = 4'd11; st_comp = 2'd0; st_fin = DP_RES; st_last_mul = 1'b1; end
         5'd14: begin st_term = 4'd10; st_comp = 2'd1; end
         5'd15: begin st_term = 4'd11; st_comp = 2'd1; st_fin = DP_RES; st_last_mul = 1'b1; end
         5'd16: begin st_term = 4'd10; st_comp = 2'd2; end
         5'd17: begin st_term = 4'd11; st_comp = 2'd2; st_fin = DP_RES; st_last_mul = 1'b1; end
         default: ;
      endcase
   end

   logic fin_ff, fin_in;  // pending finishing op after the last accumulate

   always_comb begin
      state_in = state_ff; op_in = op_ff; vec_in = vec_ff;
      iter_in = iter_ff; step_in = step_ff; fin_in = 1'b0;
      cmd = '{op: DP_NOP, vec: vec_ff, comp: st_comp, term: st_term, iter: iter_ff};
      req_take = 1'b0;
      done = 1'b0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: if (req_valid) begin
            req_take = 1'b1; op_in = req_opcode; state_in = S_DECODE;
         end
         S_DECODE: begin
            if (op_ff == OP_YAW || op_ff == OP_PITCH) state_in = S_PHASE;
            else begin
               if (op_ff == OP_LOAD) cmd.op = DP_LOAD;
               state_in = S_DONE;
            end
         end
         S_PHASE: begin cmd.op = DP_PHASE; state_in = S_PHASE_HI; end
         S_PHASE_HI: begin cmd.op = DP_PHASE_HI; state_in = S_FOLD; end
         S_FOLD: begin cmd.op = DP_FOLD; iter_in = 5'd0; state_in = S_CORDIC; end
         S_CORDIC: begin
            cmd.op = DP_CORDIC;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == LastIter) state_in = S_FLIP;
         end
         S_FLIP: begin cmd.op = DP_FLIP; vec_in = 2'd0; state_in = S_SETVEC; end
         S_SETVEC: begin cmd.op = DP_SETVEC; step_in = 5'd0; state_in = S_SEL; end
         S_SEL: begin
            // Product is selected here; it is registered for the next cycle.
            state_in = S_ACC;
         end
         S_ACC: begin
            if (!fin_ff) begin
               cmd.op = DP_MUL;
               if (st_last_mul) begin fin_in = 1'b1; end
               else begin step_in = step_ff + 5'd1; state_in = S_SEL; end
            end else begin
               cmd.op = st_fin;
               if (step_ff == 5'd17) begin
                  if (vec_ff == 2'd3 || (vec_ff == 2'd2 && op_ff == OP_PITCH))
                     state_in = S_DONE;
                  else begin vec_in = vec_ff + 2'd1; state_in = S_SETVEC; end
               end else begin
                  step_in = step_ff + 5'd1; state_in = S_SEL;
               end
            end
         end
         S_DONE: begin done = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; op_ff <= 2'd0; vec_ff <= 2'd0;
         iter_ff <= 5'd0; step_ff <= 5'd0; fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in; op_ff <= op_in; vec_ff <= vec_in;
         iter_ff <= iter_in; step_ff <= step_in; fin_ff <= fin_in;
      end
   end
endmodule
`default_nettype wire

[rtl/orbit_camera_rotator_core.sv]
// ----------------------------------------------------------------------------
// orbit_camera_rotator_core: orbit camera rotator top level
// Register file, result register, controller and datapath.
// ----------------------------------------------------------------------------
// One event word is taken while the block is idle, and the block then stalls
// its input until the event is done. A yaw or pitch runs a phase multiply in
// a low and a high part, a fold, CORDIC_STEPS CORDIC iterations and a sign
// fix, and then each turned vector goes through the single shared multiplier:
// a step to pick the base, eighteen products that are each selected and then
// accumulated, and ten finishing steps (dot, three n0, three n2 and three
// write backs). A yaw turns four vectors and a pitch three. A load or an
// unused opcode goes from decode straight to done. After any event the next
// word can be taken in the cycle its result word becomes valid. The result
// word sits in an output register; while it is held there by rsp_stall the
// input is stalled too, and a result that finishes behind it waits until the
// old word leaves.
`default_nettype none
module orbit_camera_rotator_core #(
   parameter int CORDIC_STEPS = ocr_pkg::CordicStepsDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ocr_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ocr_pkg::rsp_word_type      rsp_word,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [4:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import ocr_pkg::*;

   logic signed [31:0] pivot_ff [3];
   logic signed [31:0] up_ff [3];
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;
   rsp_word_type       state_word;
   dp_cmd_type         cmd;
   logic               ctl_stall, req_take, done;
   logic [2:0]         reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];

   // Register file: a write lands on the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin pivot_ff[i] <= 32'sd0; up_ff[i] <= 32'sd0; end
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_PIVOT_X: pivot_ff[0] <= pwdata;
            REG_PIVOT_Y: pivot_ff[1] <= pwdata;
            REG_PIVOT_Z: pivot_ff[2] <= pwdata;
            REG_UP_X:    up_ff[0] <= pwdata;
            REG_UP_Y:    up_ff[1] <= pwdata;
            REG_UP_Z:    up_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PIVOT_X: prdata = pivot_ff[0];
         REG_PIVOT_Y: prdata = pivot_ff[1];
         REG_PIVOT_Z: prdata = pivot_ff[2];
         REG_UP_X:    prdata = up_ff[0];
         REG_UP_Y:    prdata = up_ff[1];
         REG_UP_Z:    prdata = up_ff[2];
         default:     prdata = 32'd0;
      endcase
   end

   // While a finished word is held by rsp_stall, no new event is taken, so
   // the camera state cannot move on under a result that still waits.
   logic ctl_valid;
   assign ctl_valid = req_valid && !(rsp_valid_ff && rsp_stall);
   assign req_stall = ctl_stall || (rsp_valid_ff && rsp_stall);

   ocr_controller #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctl (
      .clock(clock), .reset(reset), .req_valid(ctl_valid),
      .req_opcode(req_word.opcode), .req_stall(ctl_stall), .req_take(req_take),
      .cmd(cmd), .done(done)
   );

   ocr_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_word(req_word),
      .req_take(req_take), .pivot(pivot_ff), .up_axis(up_ff),
      .state_word(state_word)
   );

   // The done strobe comes in the cycle after the last write back; the state
   // word is then current. If the output register still holds an
   // undelivered word, the new result is marked pending and copied in at
   // the edge where the old word leaves.
   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if ((done || pend_ff) && !(rsp_valid_ff && rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff  <= state_word;
            pend_ff      <= 1'b0;
         end else begin
            if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
            if (done) pend_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
endmodule
`default_nettype wire
